>>> rtl/core/rotation_matrix_to_quaternion_unit_assert.svh
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
// Files that assert include this header; it needs clk and rst in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define RMQ_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define RMQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/rmq_pkg.sv
// Shared constants and helpers for the rotation-matrix-to-quaternion block.
// No dependencies.
`timescale 1ns / 1ps

package rmq_pkg;
  localparam int FRAC_BITS_DEF = 14;
  localparam int IO_W = 16;

  // Width of a signed component (radicand or numerator) for a given fraction width.
  function automatic int comp_width(input int fb);
    int mb;
    mb = (fb > 17) ? fb : 17;
    return mb + 3;
  endfunction
endpackage

>>> rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside. Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module rmq_sqrt #(
  parameter int RW = 20,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*RW-1:0] value,
  input  logic [SW-1:0]   side_in,
  output logic            out_vld,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);
  localparam int LW = 2 * RW;

  logic [LW-1:0] rem  [0:RW];
  logic [LW-1:0] acc  [0:RW];
  logic [SW-1:0] side [0:RW];
  logic          vld  [0:RW];

  assign rem[0]  = value;
  assign acc[0]  = '0;
  assign side[0] = side_in;
  assign vld[0]  = in_vld;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam logic [LW-1:0] BIT = LW'(1) << (2 * (RW - 1 - i));
    logic [LW-1:0] trial;
    logic          take;
    assign trial = acc[i] + BIT;
    assign take  = rem[i] >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= take ? rem[i] - trial : rem[i];
        acc[i+1]  <= take ? (acc[i] >> 1) + BIT : acc[i] >> 1;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_vld  = vld[RW];
  assign root     = acc[RW][RW-1:0];
  assign side_out = side[RW];
endmodule

>>> rtl/core/rotation_matrix_to_quaternion_unit.sv
// Top level: rotation matrix (Q2.14) to unit quaternion, Shepperd's method.
// Uses rmq_pkg, rmq_sqrt and the assertion header.
//
// Usage:
//   Input channel in_valid/in_ready carries nine matrix elements m_rIcJ.
//   Output channel out_valid/out_ready carries quat_x..quat_w and degenerate.
//   One item enters per cycle; throughput is one item per clock while
//   out_ready does not stall the pipeline. Stages: one picks the branch,
//   one squares, one sums, CW stages of square root at one root bit each
//   (CW = max(FRAC_BITS,17)+3), FRAC_BITS+1 stages of division at one
//   quotient bit each per lane, one output stage.
//   The four components divide in parallel lanes sharing one root.
//   Reset (rst, synchronous) empties the pipeline; out_valid drops at once.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready falls; nothing is lost or repeated.
//   Degenerate items (non-positive radicand or zero length) return the
//   identity quaternion with degenerate set.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r0c0,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r0c1,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r0c2,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r1c0,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r1c1,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r1c2,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r2c0,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r2c1,
  input  logic signed [rmq_pkg::IO_W-1:0]   m_r2c2,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rmq_pkg::IO_W-1:0]   quat_x,
  output logic signed [rmq_pkg::IO_W-1:0]   quat_y,
  output logic signed [rmq_pkg::IO_W-1:0]   quat_z,
  output logic signed [rmq_pkg::IO_W-1:0]   quat_w,
  output logic                              degenerate
);
  import rmq_pkg::*;
  `include "rotation_matrix_to_quaternion_unit_assert.svh"

  localparam int CW = comp_width(FRAC_BITS);
  localparam int LW = 2 * CW;
  localparam int QW = FRAC_BITS + 1;
  localparam int SW = 4 * CW + 1;
  // Wide enough to hold the quotient and the value 32768.
  localparam int XW = (QW > IO_W) ? QW : IO_W + 1;
  localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic [XW-1:0] SAT_POS = XW'(32767);
  localparam logic [XW-1:0] SAT_NEG = XW'(32768);
  localparam logic signed [IO_W-1:0] W_IDENT =
    (FRAC_BITS >= 15) ? IO_W'(32767) : IO_W'(1 << FRAC_BITS);

  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // Stage 1: branch selection and scaled components (order x, y, z, w)
  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [CW-1:0] trace, rad;
  logic signed [CW-1:0] c_next [4];
  logic signed [CW-1:0] c1 [4];
  logic                 rpos1, v1;

  always_comb begin
    e00 = CW'(m_r0c0); e01 = CW'(m_r0c1); e02 = CW'(m_r0c2);
    e10 = CW'(m_r1c0); e11 = CW'(m_r1c1); e12 = CW'(m_r1c2);
    e20 = CW'(m_r2c0); e21 = CW'(m_r2c1); e22 = CW'(m_r2c2);
    trace = e00 + e11 + e22;
    if (trace > 0) begin
      rad = trace + ONE;
      c_next[0] = e21 - e12; c_next[1] = e02 - e20;
      c_next[2] = e10 - e01; c_next[3] = rad;
    end else if (e00 > e11 && e00 > e22) begin
      rad = ONE + e00 - e11 - e22;
      c_next[0] = rad;       c_next[1] = e01 + e10;
      c_next[2] = e02 + e20; c_next[3] = e21 - e12;
    end else if (e11 > e22) begin
      rad = ONE + e11 - e00 - e22;
      c_next[0] = e01 + e10; c_next[1] = rad;
      c_next[2] = e12 + e21; c_next[3] = e02 - e20;
    end else begin
      rad = ONE + e22 - e00 - e11;
      c_next[0] = e02 + e20; c_next[1] = e12 + e21;
      c_next[2] = rad;       c_next[3] = e10 - e01;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      c1    <= c_next;
      rpos1 <= rad > 0;
    end
  end

  // Stage 2: squares of the magnitudes
  logic signed [CW-1:0] c2 [4];
  logic [LW-1:0]        sq2 [4];
  logic                 rpos2, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq2[k] <= LW'(c1[k] < 0 ? -c1[k] : c1[k]) * LW'(c1[k] < 0 ? -c1[k] : c1[k]);
      end
      c2    <= c1;
      rpos2 <= rpos1;
    end
  end

  // Stage 3: squared length
  logic [LW-1:0] lsq3;
  logic [SW-1:0] side3;
  logic          v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      lsq3  <= sq2[0] + sq2[1] + sq2[2] + sq2[3];
      side3 <= {rpos2, c2[3], c2[2], c2[1], c2[0]};
    end
  end

  // Square root
  logic [CW-1:0] len4;
  logic [SW-1:0] side4;
  logic          v4;

  rmq_sqrt #(.RW(CW), .SW(SW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (v3),
    .value    (lsq3),
    .side_in  (side3),
    .out_vld  (v4),
    .root     (len4),
    .side_out (side4)
  );

  // Division lanes: quotient (|c| << FRAC_BITS) / len, one bit per stage.
  // |c| never exceeds len, so the quotient fits FRAC_BITS+1 bits.
  logic [CW:0]   drem [0:QW][4];
  logic [QW-1:0] dquo [0:QW][4];
  logic          dneg [0:QW][4];
  logic [CW-1:0] dlen [0:QW];
  logic          ddeg [0:QW];
  logic          dvld [0:QW];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [CW-1:0] c;
      c = side4[k*CW +: CW];
      drem[0][k] = (CW+1)'(c < 0 ? -c : c);
      dquo[0][k] = '0;
      dneg[0][k] = c < 0;
    end
    dlen[0] = len4;
    ddeg[0] = !side4[SW-1] || (len4 == '0);
    dvld[0] = v4;
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [CW:0] trial [4];
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        trial[k] = (s == 0) ? drem[s][k] : (drem[s][k] << 1);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[s+1] <= 1'b0;
      end else if (en) begin
        dvld[s+1] <= dvld[s];
      end
      if (en) begin
        for (int k = 0; k < 4; k++) begin
          if (trial[k] >= (CW+1)'(dlen[s])) begin
            drem[s+1][k] <= trial[k] - (CW+1)'(dlen[s]);
            dquo[s+1][k] <= {dquo[s][k][QW-2:0], 1'b1};
          end else begin
            drem[s+1][k] <= trial[k];
            dquo[s+1][k] <= {dquo[s][k][QW-2:0], 1'b0};
          end
          dneg[s+1][k] <= dneg[s][k];
        end
        dlen[s+1] <= dlen[s];
        ddeg[s+1] <= ddeg[s];
      end
    end
  end

  // Output stage: sign, saturate, identity override
  logic signed [IO_W-1:0] q_next [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dneg[QW][k]) begin
        q_next[k] = (XW'(dquo[QW][k]) >= SAT_NEG) ? IO_W'(-32768) : -IO_W'(dquo[QW][k]);
      end else begin
        q_next[k] = (XW'(dquo[QW][k]) >= SAT_POS) ? IO_W'(32767) : IO_W'(dquo[QW][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvld[QW];
    end
    if (en) begin
      degenerate <= ddeg[QW];
      quat_x     <= ddeg[QW] ? '0 : q_next[0];
      quat_y     <= ddeg[QW] ? '0 : q_next[1];
      quat_z     <= ddeg[QW] ? '0 : q_next[2];
      quat_w     <= ddeg[QW] ? W_IDENT : q_next[3];
    end
  end

  logic ident_out;
  assign ident_out = quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == W_IDENT;

  `RMQ_ASSERT_IMPLY(a_degen_ident, out_valid && degenerate, ident_out, "degenerate not identity")
  `RMQ_ASSERT_IMPLY(a_stall_only, !in_ready, out_valid && !out_ready, "input held without stall")
  `RMQ_ASSERT_NEXT(a_take_item, in_valid && in_ready, v1, "item did not enter stage one")
endmodule

>>> verif/rotation_matrix_to_quaternion_checker.sv
// Checker for the rotation-matrix-to-quaternion unit: predicts each quaternion
// from the accepted matrix and compares it against the output channel.
// Uses rmq_pkg for widths only.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_checker #(
  parameter int FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [rmq_pkg::IO_W-1:0] m_r0c0, m_r0c1, m_r0c2,
  input  logic signed [rmq_pkg::IO_W-1:0] m_r1c0, m_r1c1, m_r1c2,
  input  logic signed [rmq_pkg::IO_W-1:0] m_r2c0, m_r2c1, m_r2c2,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic signed [rmq_pkg::IO_W-1:0] quat_x, quat_y, quat_z, quat_w,
  input  logic                            degenerate,
  output int                              mismatches,
  output int                              pending
);
  typedef struct packed {
    logic signed [15:0] x, y, z, w;
    logic               degen;
  } quat_t;

  quat_t quat_fifo[$];

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint scale_div(input longint c, input longint len);
    longint q;
    q = ((c < 0 ? -c : c) << FRAC_BITS) / len;
    return c < 0 ? -q : q;
  endfunction

  function automatic quat_t shepperd_quat(input longint a00, a01, a02, a10, a11, a12,
                                          a20, a21, a22);
    longint one, tr, r, x, y, z, w, len;
    quat_t q;
    one = longint'(1) << FRAC_BITS;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      r = tr + one; w = r; x = a21 - a12; y = a02 - a20; z = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      r = one + a00 - a11 - a22; w = a21 - a12; x = r; y = a01 + a10; z = a02 + a20;
    end else if (a11 > a22) begin
      r = one + a11 - a00 - a22; w = a02 - a20; x = a01 + a10; y = r; z = a12 + a21;
    end else begin
      r = one + a22 - a00 - a11; w = a10 - a01; x = a02 + a20; y = a12 + a21; z = r;
    end
    if (r < 0) r = 0;
    len = longint'(root_floor(x * x + y * y + z * z + w * w));
    if (r == 0 || len == 0) begin
      q.x = 0; q.y = 0; q.z = 0; q.w = clip16(one); q.degen = 1'b1;
    end else begin
      q.x = clip16(scale_div(x, len));
      q.y = clip16(scale_div(y, len));
      q.z = clip16(scale_div(z, len));
      q.w = clip16(scale_div(w, len));
      q.degen = 1'b0;
    end
    return q;
  endfunction

  assign pending = quat_fifo.size();

  always @(posedge clk) begin
    quat_t e;
    if (rst) begin
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready)
        quat_fifo.push_back(shepperd_quat(m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1,
                                          m_r1c2, m_r2c0, m_r2c1, m_r2c2));
      if (out_valid && out_ready) begin
        if (quat_fifo.size() == 0) begin
          if (mismatches < 10) $display("unexpected quaternion item at %0t", $time);
          mismatches <= mismatches + 1;
        end else begin
          e = quat_fifo.pop_front();
          if (e.x !== quat_x || e.y !== quat_y || e.z !== quat_z || e.w !== quat_w ||
              e.degen !== degenerate) begin
            if (mismatches < 10)
              $display("quat mismatch: exp %0d %0d %0d %0d d%0b got %0d %0d %0d %0d d%0b",
                       e.x, e.y, e.z, e.w, e.degen,
                       quat_x, quat_y, quat_z, quat_w, degenerate);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/rotation_matrix_to_quaternion_unit_tb.sv
// Testbench top for rotation_matrix_to_quaternion_unit: drives matrices with
// random idling, lets the checker compare results, and prints the verdict.
// Uses rotation_matrix_to_quaternion_checker and rmq_pkg.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit_tb;
  localparam int ONE = 1 << 14;
  localparam int N_RANDOM = 880;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid, degenerate;
  logic signed [15:0] mat[9];
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  int mismatches, pending, cycles = 0;
  bit quiet_tail = 0;

  always #6 clk = ~clk;

  initial foreach (mat[i]) mat[i] = 0;

  rotation_matrix_to_quaternion_unit u_dut (
    .clk, .rst, .in_valid, .in_ready,
    .m_r0c0(mat[0]), .m_r0c1(mat[1]), .m_r0c2(mat[2]),
    .m_r1c0(mat[3]), .m_r1c1(mat[4]), .m_r1c2(mat[5]),
    .m_r2c0(mat[6]), .m_r2c1(mat[7]), .m_r2c2(mat[8]),
    .out_valid, .out_ready, .quat_x, .quat_y, .quat_z, .quat_w, .degenerate
  );

  rotation_matrix_to_quaternion_checker u_chk (
    .clk, .rst, .in_valid, .in_ready,
    .m_r0c0(mat[0]), .m_r0c1(mat[1]), .m_r0c2(mat[2]),
    .m_r1c0(mat[3]), .m_r1c1(mat[4]), .m_r1c2(mat[5]),
    .m_r2c0(mat[6]), .m_r2c1(mat[7]), .m_r2c2(mat[8]),
    .out_valid, .out_ready, .quat_x, .quat_y, .quat_z, .quat_w, .degenerate,
    .mismatches, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver: stall in bursts of random length, none in the tail.
  initial begin
    int k;
    @(negedge rst);
    forever begin
      @(posedge clk);
      out_ready <= 1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 3);
        repeat (k) begin
          @(posedge clk);
          out_ready <= 0;
        end
      end
    end
  end

  task automatic send_matrix(input logic signed [15:0] m[9]);
    int k;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, 3);
      in_valid <= 0;
      repeat (k) @(posedge clk);
    end
    in_valid <= 1;
    foreach (m[i]) mat[i] <= m[i];
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [15:0] near(input int c, input int spread);
    int v;
    v = c + $urandom_range(0, 2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  initial begin
    logic signed [15:0] m[9];
    int sel, sg;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: identity, half-turns on each axis, zero matrix, extremes, ties.
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};      send_matrix(m);
    m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};    send_matrix(m);
    m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};    send_matrix(m);
    m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};    send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};            send_matrix(m);
    m = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};     send_matrix(m);
    foreach (m[i]) m[i] = 16'sh7fff;             send_matrix(m);
    foreach (m[i]) m[i] = -16'sh8000;            send_matrix(m);
    m = '{-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
          16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000}; send_matrix(m);
    m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};   send_matrix(m); // all ties
    m = '{-16'sh8000, 0, 0, 0, -16'sh8000, 0, 0, 0, -16'sh8000}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, -ONE};         send_matrix(m); // negative trace
    m = '{-ONE, 0, 0, 0, 0, 0, 0, 0, 0};         send_matrix(m);
    m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 16'sh7fff,
          16'sh7fff, 16'sh7fff, -16'sh8000};     send_matrix(m); // large elements
    m = '{0, ONE, 0, -ONE, 0, 0, 0, 0, 0};       send_matrix(m);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 150) quiet_tail = 1;
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        foreach (m[i]) m[i] = 16'($urandom());
      end else if (sel < 5) begin
        foreach (m[i]) m[i] = near(0, ONE + 2000);
      end else begin
        // Near-rotation: signed permutation-like diagonal with small noise.
        foreach (m[i]) m[i] = near(0, 6000);
        sg = $urandom_range(0, 7);
        m[0] = near(sg[0] ? ONE : -ONE, 5000);
        m[4] = near(sg[1] ? ONE : -ONE, 5000);
        m[8] = near(sg[2] ? ONE : -ONE, 5000);
      end
      send_matrix(m);
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("rotation_matrix_to_quaternion_unit_tb: done, clean");
    else
      $display("rotation_matrix_to_quaternion_unit_tb: done, errors");
    $finish;
  end
endmodule
